FILE: sv/pdc_pkg.sv
// Package for the pixel decimate and convert block.
// Holds shared constants, types, codes and the divide-by-255 helper.
// No dependencies.
`default_nettype none

package pdc_pkg;

    // Width of the column counter.
    localparam int CNT_W = 16;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LAYOUT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_OUTPUT   = 8'd3;

    // Q0.16 luma coefficients.
    localparam logic [15:0] COEF_R = 16'd19661;
    localparam logic [15:0] COEF_G = 16'd38666;
    localparam logic [15:0] COEF_B = 16'd7209;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // Source pixel layouts.
    typedef enum logic [1:0] {
        LAYOUT_GRAY       = 2'd0,
        LAYOUT_GRAY_ALPHA = 2'd1,
        LAYOUT_RGB        = 2'd2,
        LAYOUT_RGBA       = 2'd3
    } t_layout;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LUMA,
        ST_PREM
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic do_luma;
        logic load_out;
    } t_pdc_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic keep;
    } t_pdc_sts;

    // c * a / 255, rounded to nearest.
    function automatic logic [7:0] mul_div255(input logic [7:0] c, input logic [7:0] a);
        logic [16:0] x;
        logic [16:0] y;
        x = {1'b0, 16'(c) * 16'(a)} + 17'd128;
        y = x + (x >> 8);
        return y[15:8];
    endfunction

endpackage

`default_nettype wire

FILE: sv/pdc_in_if.sv
// Input pixel channel: valid/ready handshake with four pixel bytes.
// No dependencies.
`default_nettype none

interface pdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;

    modport source (output valid, output byte0, output byte1, output byte2,
                    output byte3, input ready);
    modport sink   (input valid, input byte0, input byte1, input byte2,
                    input byte3, output ready);
endinterface

`default_nettype wire

FILE: sv/pdc_out_if.sv
// Output pixel channel: valid/ready handshake with four colour channels.
// No dependencies.
`default_nettype none

interface pdc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (output valid, output out_red, output out_green,
                    output out_blue, output out_alpha, input ready);
    modport sink   (input valid, input out_red, input out_green,
                    input out_blue, input out_alpha, output ready);
endinterface

`default_nettype wire

FILE: sv/pdc_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on pdc_pkg for the field widths.
`default_nettype none

interface pdc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pdc_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [pdc_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: sv/pdc_ctrl.sv
// Controller for the pixel decimate and convert block: sequences capture,
// luma and premultiply, and owns the output valid flag. Depends on pdc_pkg.
`default_nettype none

module pdc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  pdc_pkg::t_pdc_sts i_sts,
    output pdc_pkg::t_pdc_cmd o_cmd
);

    pdc_pkg::t_state r_state;
    pdc_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // The output slot is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pdc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.keep) begin
                        n_state = pdc_pkg::ST_LUMA;
                    end
                end
            end
            pdc_pkg::ST_LUMA: begin
                o_cmd.do_luma = 1'b1;
                n_state       = pdc_pkg::ST_PREM;
            end
            pdc_pkg::ST_PREM: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = pdc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pdc_pkg::ST_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: sv/pdc_datapath.sv
// Datapath for the pixel decimate and convert block: configuration
// registers, phase counters, luma and premultiply. Depends on pdc_pkg.
`default_nettype none

module pdc_datapath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    pdc_cfg_if.sink           i_cfg,
    input  wire  [7:0]        i_byte0,
    input  wire  [7:0]        i_byte1,
    input  wire  [7:0]        i_byte2,
    input  wire  [7:0]        i_byte3,
    input  pdc_pkg::t_pdc_cmd i_cmd,
    output pdc_pkg::t_pdc_sts o_sts,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_alpha
);

    // Configuration registers.
    logic [15:0]      r_source_width;
    logic [7:0]       r_sample_step;
    pdc_pkg::t_layout r_source_layout;
    logic             r_gray_output;

    // Decimation counters.
    logic [pdc_pkg::CNT_W-1:0] r_col;
    logic [7:0]                r_col_phase;
    logic [7:0]                r_row_phase;

    // Captured pixel, luma and output registers.
    logic [7:0] r_b0, r_b1, r_b2, r_b3;
    logic [7:0] r_luma;
    logic [7:0] r_out_red, r_out_green, r_out_blue, r_out_alpha;

    logic [7:0]                step_eff;
    logic [pdc_pkg::CNT_W-1:0] width_eff;
    logic [pdc_pkg::CNT_W:0]   col_inc;
    logic                      row_end;
    logic [8:0]                col_ph_inc;
    logic [8:0]                row_ph_inc;
    logic [7:0]                col_ph_nxt;
    logic [7:0]                row_ph_nxt;
    logic [23:0]               luma_sum;
    logic [7:0]                m0_c, m0_a;
    logic [7:0]                md0, md1, md2;
    logic [7:0]                n_red, n_green, n_blue, n_alpha;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= 16'd1;
            r_sample_step   <= 8'd1;
            r_source_layout <= pdc_pkg::LAYOUT_RGBA;
            r_gray_output   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                pdc_pkg::CFG_SOURCE_WIDTH:  r_source_width  <= i_cfg.wdata[15:0];
                pdc_pkg::CFG_SAMPLE_STEP:   r_sample_step   <= i_cfg.wdata[7:0];
                pdc_pkg::CFG_SOURCE_LAYOUT: r_source_layout <= pdc_pkg::t_layout'(i_cfg.wdata[1:0]);
                pdc_pkg::CFG_GRAY_OUTPUT:   r_gray_output   <= i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    // Counter advance. A zero width or step behaves as one.
    always_comb begin
        step_eff   = (r_sample_step == 8'd0) ? 8'd1 : r_sample_step;
        width_eff  = (r_source_width == 16'd0) ? 16'd1 : r_source_width;
        col_inc    = {1'b0, r_col} + 17'd1;
        row_end    = (col_inc >= {1'b0, width_eff}) || (&r_col);
        col_ph_inc = {1'b0, r_col_phase} + 9'd1;
        row_ph_inc = {1'b0, r_row_phase} + 9'd1;
        col_ph_nxt = (col_ph_inc >= {1'b0, step_eff}) ? 8'd0 : col_ph_inc[7:0];
        row_ph_nxt = (row_ph_inc >= {1'b0, step_eff}) ? 8'd0 : row_ph_inc[7:0];
    end

    assign o_sts.keep = (r_col_phase == 8'd0) && (r_row_phase == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_col_phase <= 8'd0;
            r_row_phase <= 8'd0;
        end else if (i_cmd.capture) begin
            if (row_end) begin
                r_col       <= '0;
                r_col_phase <= 8'd0;
                r_row_phase <= row_ph_nxt;
            end else begin
                r_col       <= col_inc[pdc_pkg::CNT_W-1:0];
                r_col_phase <= col_ph_nxt;
            end
        end
    end

    // Pixel capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_b0 <= i_byte0;
            r_b1 <= i_byte1;
            r_b2 <= i_byte2;
            r_b3 <= i_byte3;
        end
    end

    // Luma: Q0.16 weighted sum, top byte kept.
    assign luma_sum = 24'(pdc_pkg::COEF_R) * 24'(r_b0)
                    + 24'(pdc_pkg::COEF_G) * 24'(r_b1)
                    + 24'(pdc_pkg::COEF_B) * 24'(r_b2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_luma) begin
            r_luma <= luma_sum[23:16];
        end
    end

    // Premultiply. The first unit serves luma by alpha and gray by alpha.
    always_comb begin
        m0_c = (r_gray_output && (r_source_layout == pdc_pkg::LAYOUT_RGBA)) ? r_luma : r_b0;
        m0_a = (r_source_layout == pdc_pkg::LAYOUT_GRAY_ALPHA) ? r_b1 : r_b3;
        md0  = pdc_pkg::mul_div255(m0_c, m0_a);
        md1  = pdc_pkg::mul_div255(r_b1, r_b3);
        md2  = pdc_pkg::mul_div255(r_b2, r_b3);

        n_red   = 8'd0;
        n_green = 8'd0;
        n_blue  = 8'd0;
        n_alpha = 8'd0;
        if (r_gray_output) begin
            case (r_source_layout)
                pdc_pkg::LAYOUT_GRAY:       n_red = r_b0;
                pdc_pkg::LAYOUT_GRAY_ALPHA: n_red = md0;
                pdc_pkg::LAYOUT_RGB:        n_red = r_luma;
                default:                    n_red = md0;
            endcase
        end else begin
            case (r_source_layout)
                pdc_pkg::LAYOUT_GRAY: begin
                    n_red   = r_b0;
                    n_green = r_b0;
                    n_blue  = r_b0;
                    n_alpha = pdc_pkg::ALPHA_OPAQUE;
                end
                pdc_pkg::LAYOUT_GRAY_ALPHA: begin
                    n_red   = md0;
                    n_green = md0;
                    n_blue  = md0;
                    n_alpha = r_b1;
                end
                pdc_pkg::LAYOUT_RGB: begin
                    n_red   = r_b0;
                    n_green = r_b1;
                    n_blue  = r_b2;
                    n_alpha = pdc_pkg::ALPHA_OPAQUE;
                end
                default: begin
                    n_red   = md0;
                    n_green = md1;
                    n_blue  = md2;
                    n_alpha = r_b3;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_red   <= n_red;
            r_out_green <= n_green;
            r_out_blue  <= n_blue;
            r_out_alpha <= n_alpha;
        end
    end

    assign o_red   = r_out_red;
    assign o_green = r_out_green;
    assign o_blue  = r_out_blue;
    assign o_alpha = r_out_alpha;

endmodule

`default_nettype wire

FILE: sv/pixel_decimate_and_convert_top.sv
// Top level of the pixel decimate and convert block.
// Depends on pdc_pkg, the three channel interfaces, pdc_ctrl and pdc_datapath.
//
// Usage:
// Pixels arrive in raster order on i_pix, one per transfer. A column counter
// and a column phase counter step on every transfer, a row phase counter at
// each row end; a pixel is kept only when both phases are zero, otherwise it
// is dropped with no result. A kept pixel is turned into gray (out_red, other
// channels zero) or into premultiplied RGBA, and leaves on o_pix.
// Configuration is written on i_cfg (index 0 source width, 1 sample step,
// 2 source layout, 3 gray output); writes are always accepted and should be
// made while the block is idle.
// A dropped pixel ends in the idle state, so the next pixel can be taken; a
// kept pixel goes through capture, luma register and premultiply into the
// output register, set by the controller sequence over the shared luma and
// premultiply units, and input stops until that sequence is back in idle.
// The output register holds one result; the next pixel is accepted while it
// waits. If the receiver stalls, the following kept pixel waits in the
// premultiply step and input stops until the output register frees.
// Reset restores the register defaults (width 1, step 1, RGBA source, RGBA
// output) and clears the counters and the output valid flag.
`default_nettype none

module pixel_decimate_and_convert_top (
    input  wire      i_clk,
    input  wire      i_rst_n,
    pdc_in_if.sink   i_pix,
    pdc_out_if.source o_pix,
    pdc_cfg_if.sink  i_cfg
);

    pdc_pkg::t_pdc_cmd cmd;
    pdc_pkg::t_pdc_sts sts;

    pdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_pix.valid),
        .i_out_ready (o_pix.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pdc_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_byte0 (i_pix.byte0),
        .i_byte1 (i_pix.byte1),
        .i_byte2 (i_pix.byte2),
        .i_byte3 (i_pix.byte3),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_red   (o_pix.out_red),
        .o_green (o_pix.out_green),
        .o_blue  (o_pix.out_blue),
        .o_alpha (o_pix.out_alpha)
    );

endmodule

`default_nettype wire
